>>> sv/ptdpp_pkg.sv
package ptdpp_pkg;

   // image size in pixels
   localparam int IMAGE_WIDTH  = 1280;
   localparam int IMAGE_HEIGHT = 720;

   // field widths
   localparam int PT_W    = 16;
   localparam int COL_W   = 11;
   localparam int ROW_W   = 10;
   localparam int DEPTH_W = 16;
   localparam int FOC_W   = 24;

   // camera coordinate in mm * 2^14, signed
   localparam int SW = 34;
   // projection numerator, signed
   localparam int NW = 60;
   // divisor 16 * camera z
   localparam int DW = SW + 4;
   // quotient bits produced by the divider, one per stage
   localparam int QB = 12;
   // split point of the camera coordinate for the intrinsic products
   localparam int LO_W = 17;

   // configuration register map
   localparam int ADDR_W = 6;
   localparam int DATA_W = 64;
   typedef enum logic [2:0] {
      REG_ROW_X     = 3'd0,
      REG_ROW_Y     = 3'd1,
      REG_ROW_Z     = 3'd2,
      REG_FOCAL     = 3'd3,
      REG_PRINCIPAL = 3'd4
   } reg_index_type;

endpackage

>>> sv/point_to_depth_pixel_projector.sv
// throughput: one point per cycle; the whole pipeline holds while a response waits
// the path is five arithmetic stages, a 12-stage restoring divider
// (one quotient bit per stage, column and row lanes in parallel) and an output register
// reset: synchronous, active high; clears all valid bits and the configuration to zero
module point_to_depth_pixel_projector (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [ptdpp_pkg::PT_W-1:0]      req_point_x,
   input  logic signed [ptdpp_pkg::PT_W-1:0]      req_point_y,
   input  logic signed [ptdpp_pkg::PT_W-1:0]      req_point_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [ptdpp_pkg::COL_W-1:0]            rsp_pixel_col,
   output logic [ptdpp_pkg::ROW_W-1:0]            rsp_pixel_row,
   output logic [ptdpp_pkg::DEPTH_W-1:0]          rsp_depth_mm,
   output logic                                   rsp_write_valid,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [ptdpp_pkg::ADDR_W-1:0]           paddr,
   input  logic [ptdpp_pkg::DATA_W-1:0]           pwdata,
   output logic [ptdpp_pkg::DATA_W-1:0]           prdata,
   output logic                                   pready
);

   localparam int SW  = ptdpp_pkg::SW;
   localparam int NW  = ptdpp_pkg::NW;
   localparam int DW  = ptdpp_pkg::DW;
   localparam int QB  = ptdpp_pkg::QB;
   localparam int LO  = ptdpp_pkg::LO_W;
   localparam int FW  = ptdpp_pkg::FOC_W;
   localparam int HI  = SW - LO;

   // configuration registers
   logic [63:0]       coef_ff [3];
   logic [2*FW-1:0]   focal_ff;
   logic [2*FW-1:0]   center_ff;
   logic              csr_write;
   logic [2:0]        csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[ptdpp_pkg::ADDR_W-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) coef_ff[r] <= '0;
         focal_ff  <= '0;
         center_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            ptdpp_pkg::REG_ROW_X:     coef_ff[0] <= pwdata;
            ptdpp_pkg::REG_ROW_Y:     coef_ff[1] <= pwdata;
            ptdpp_pkg::REG_ROW_Z:     coef_ff[2] <= pwdata;
            ptdpp_pkg::REG_FOCAL:     focal_ff   <= pwdata[2*FW-1:0];
            ptdpp_pkg::REG_PRINCIPAL: center_ff  <= pwdata[2*FW-1:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (csr_index)
         ptdpp_pkg::REG_ROW_X:     prdata = coef_ff[0];
         ptdpp_pkg::REG_ROW_Y:     prdata = coef_ff[1];
         ptdpp_pkg::REG_ROW_Z:     prdata = coef_ff[2];
         ptdpp_pkg::REG_FOCAL:     prdata = {{(64-2*FW){1'b0}}, focal_ff};
         ptdpp_pkg::REG_PRINCIPAL: prdata = {{(64-2*FW){1'b0}}, center_ff};
         default:                  prdata = '0;
      endcase
   end

   // pipeline advance: everything moves when the output register is free
   logic rsp_valid_ff;
   logic adv;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   logic signed [15:0] pt [3];
   assign pt[0] = req_point_x;
   assign pt[1] = req_point_y;
   assign pt[2] = req_point_z;

   // stage 1: rotation products
   logic               v1_ff;
   logic signed [31:0] prod_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               prod_ff[r][c] <= $signed(coef_ff[r][16*c +: 16]) * pt[c];
      end
   end

   // stage 2: row sums plus translation
   logic                v2_ff;
   logic signed [SW-1:0] cam_ff [3];

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++)
            cam_ff[r] <= SW'(prod_ff[r][0]) + SW'(prod_ff[r][1]) + SW'(prod_ff[r][2])
                       + (SW'($signed(coef_ff[r][63:48])) <<< 14);
      end
   end

   // stage 3: intrinsic partial products, lane 0 column, lane 1 row
   logic                       v3_ff;
   logic [FW+LO-1:0]           flo_ff [2];
   logic signed [FW+HI:0]      fhi_ff [2];
   logic [FW+LO-1:0]           clo_ff [2];
   logic signed [FW+HI:0]      chi_ff [2];
   logic signed [SW-1:0]       sz3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 2; l++) begin
            flo_ff[l] <= focal_ff[FW*l +: FW] * cam_ff[l][LO-1:0];
            fhi_ff[l] <= $signed({1'b0, focal_ff[FW*l +: FW]}) * $signed(cam_ff[l][SW-1:LO]);
            clo_ff[l] <= center_ff[FW*l +: FW] * cam_ff[2][LO-1:0];
            chi_ff[l] <= $signed({1'b0, center_ff[FW*l +: FW]}) * $signed(cam_ff[2][SW-1:LO]);
         end
         sz3_ff <= cam_ff[2];
      end
   end

   // stage 4: numerators, divisor, depth
   logic                 v4_ff;
   logic signed [NW-1:0] num_ff [2];
   logic [DW-1:0]        den4_ff;
   logic                 pos4_ff;
   logic [15:0]          dep4_ff;
   logic [SW-1:0]        dep_full;

   assign dep_full = SW'((sz3_ff + SW'(16383)) >>> 14);

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 2; l++)
            num_ff[l] <= (NW'(fhi_ff[l]) <<< LO) + NW'(flo_ff[l])
                       + (NW'(chi_ff[l]) <<< LO) + NW'(clo_ff[l]);
         den4_ff <= {sz3_ff, 4'b0000};
         pos4_ff <= !sz3_ff[SW-1] && (|sz3_ff);
         dep4_ff <= (|dep_full[SW-1:16]) ? 16'hFFFF : dep_full[15:0];
      end
   end

   // divider pipeline, index 0 is the magnitude stage
   logic            dv_ff   [QB+1];
   logic [NW-1:0]   rem_ff  [QB+1][2];
   logic [QB-1:0]   q_ff    [QB+1][2];
   logic            neg_ff  [QB+1][2];
   logic            ovf_ff  [QB+1][2];
   logic [DW-1:0]   den_ff  [QB+1];
   logic            pos_ff  [QB+1];
   logic [15:0]     dep_ff  [QB+1];
   logic [NW-1:0]   rem_in  [QB+1][2];
   logic [QB-1:0]   q_in    [QB+1][2];
   logic [NW-1:0]   mag     [2];
   logic [NW-1:0]   lim;

   // magnitude and overflow check against 2^QB times the divisor
   assign lim = NW'({den4_ff, {QB{1'b0}}});
   always_comb begin
      for (int l = 0; l < 2; l++)
         mag[l] = num_ff[l][NW-1] ? NW'(-num_ff[l]) : NW'(num_ff[l]);
   end

   // one restoring step per stage
   always_comb begin
      logic [NW:0] dsh;
      logic [NW:0] trial;
      rem_in[0][0] = '0;
      rem_in[0][1] = '0;
      q_in[0][0]   = '0;
      q_in[0][1]   = '0;
      for (int k = 0; k < QB; k++) begin
         for (int l = 0; l < 2; l++) begin
            dsh   = (NW+1)'({1'b0, den_ff[k]}) << (QB-1-k);
            trial = {1'b0, rem_ff[k][l]} - dsh;
            if (!trial[NW]) begin
               rem_in[k+1][l] = trial[NW-1:0];
               q_in[k+1][l]   = q_ff[k][l] | (QB'(1) << (QB-1-k));
            end else begin
               rem_in[k+1][l] = rem_ff[k][l];
               q_in[k+1][l]   = q_ff[k][l];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QB; k++) dv_ff[k] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= v4_ff;
         for (int k = 1; k <= QB; k++) dv_ff[k] <= dv_ff[k-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 2; l++) begin
            rem_ff[0][l] <= mag[l];
            q_ff[0][l]   <= '0;
            neg_ff[0][l] <= num_ff[l][NW-1];
            ovf_ff[0][l] <= mag[l] >= lim;
         end
         den_ff[0] <= den4_ff;
         pos_ff[0] <= pos4_ff;
         dep_ff[0] <= dep4_ff;
         for (int k = 1; k <= QB; k++) begin
            for (int l = 0; l < 2; l++) begin
               rem_ff[k][l] <= rem_in[k][l];
               q_ff[k][l]   <= q_in[k][l];
               neg_ff[k][l] <= neg_ff[k-1][l];
               ovf_ff[k][l] <= ovf_ff[k-1][l];
            end
            den_ff[k] <= den_ff[k-1];
            pos_ff[k] <= pos_ff[k-1];
            dep_ff[k] <= dep_ff[k-1];
         end
      end
   end

   // bounds check and output register
   logic ok_col;
   logic ok_row;
   logic hit;
   assign ok_col = !ovf_ff[QB][0] && (neg_ff[QB][0] ? (q_ff[QB][0] == '0)
                                     : (int'(q_ff[QB][0]) < ptdpp_pkg::IMAGE_WIDTH));
   assign ok_row = !ovf_ff[QB][1] && (neg_ff[QB][1] ? (q_ff[QB][1] == '0)
                                     : (int'(q_ff[QB][1]) < ptdpp_pkg::IMAGE_HEIGHT));
   assign hit    = pos_ff[QB] && ok_col && ok_row;

   logic [ptdpp_pkg::COL_W-1:0]   col_ff;
   logic [ptdpp_pkg::ROW_W-1:0]   row_ff;
   logic [ptdpp_pkg::DEPTH_W-1:0] depth_ff;
   logic                          wv_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= dv_ff[QB];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         col_ff   <= hit ? q_ff[QB][0][ptdpp_pkg::COL_W-1:0] : '0;
         row_ff   <= hit ? q_ff[QB][1][ptdpp_pkg::ROW_W-1:0] : '0;
         depth_ff <= hit ? dep_ff[QB] : '0;
         wv_ff    <= hit;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_col   = col_ff;
   assign rsp_pixel_row   = row_ff;
   assign rsp_depth_mm    = depth_ff;
   assign rsp_write_valid = wv_ff;

   // a written pixel lies inside the image
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_valid |->
         (int'(rsp_pixel_col) < ptdpp_pkg::IMAGE_WIDTH)
         && (int'(rsp_pixel_row) < ptdpp_pkg::IMAGE_HEIGHT))
      else $error("written pixel outside image");

   // a dropped point carries all-zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_valid |->
         rsp_pixel_col == '0 && rsp_pixel_row == '0 && rsp_depth_mm == '0)
      else $error("dropped point with nonzero fields");

   // a written pixel has positive depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_valid |-> rsp_depth_mm != '0)
      else $error("written pixel with zero depth");

endmodule
